// ===== sv/battery_voltage_monitor_core_defines.svh =====
// ----------------------------------------------------------------------------
// battery voltage monitor assertion macros
// shared property forms for the core's checks
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_MONITOR_CORE_DEFINES_SVH
`define BATTERY_VOLTAGE_MONITOR_CORE_DEFINES_SVH

// condition must never hold outside reset
`define BVM_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BVM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/bvm_pkg.sv =====
// ----------------------------------------------------------------------------
// bvm_pkg
// shared constants and types of the battery voltage monitor
// ----------------------------------------------------------------------------
package bvm_pkg;

  localparam int ADC_W            = 12;
  localparam int MV_W             = 15;
  localparam int SAMPLE_COUNT_DEF = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam int VREF_MV  = 3300;
  localparam int ADC_FULL = 4095;
  localparam int DIV_NUM  = 23;
  localparam int DIV_DEN  = 3;

  localparam int MV_MAX = (((VREF_MV * ADC_FULL + ADC_FULL / 2) / ADC_FULL) * DIV_NUM
                           + DIV_DEN / 2) / DIV_DEN;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== sv/battery_voltage_monitor_core.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_monitor_core
// throughput: one sample per cycle while sample_stall is low, one result per SAMPLE_COUNT+1 samples
// the front accumulates in one adder, the back is a six-stage conversion pipe
// reset: synchronous; group position, queue, pipe valids and smoothing primed flag cleared
// ----------------------------------------------------------------------------
`include "battery_voltage_monitor_core_defines.svh"

module battery_voltage_monitor_core import bvm_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  logic [ADC_W-1:0] adc_sample,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [ADC_W-1:0] average_raw,
  output logic [MV_W-1:0]  battery_mv,
  output logic [MV_W-1:0]  filtered_mv
);

  localparam int SUM_W = $clog2(SAMPLE_COUNT * ADC_FULL + 1);

  queue_status_t    q_status;
  logic             q_push;
  logic             q_pop;
  logic [SUM_W-1:0] q_push_data;
  logic [SUM_W-1:0] q_pop_data;

  bvm_front #(
    .SAMPLE_COUNT(SAMPLE_COUNT),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .adc_sample  (adc_sample),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  bvm_queue #(
    .WIDTH(SUM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .status   (q_status)
  );

  bvm_back #(
    .SAMPLE_COUNT(SAMPLE_COUNT),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .q_data      (q_pop_data),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .average_raw (average_raw),
    .battery_mv  (battery_mv),
    .filtered_mv (filtered_mv)
  );

  `BVM_ASSERT_NEVER(a_no_push_full, clk, rst, q_push && q_status.full, "push into full queue")
  `BVM_ASSERT_NEVER(a_no_pop_empty, clk, rst, q_pop && q_status.empty, "pop from empty queue")
  `BVM_ASSERT_IMPLY(a_meas_range, clk, rst, result_valid, battery_mv <= MV_W'(MV_MAX), "mv out of range")
  `BVM_ASSERT_IMPLY(a_filt_range, clk, rst, result_valid, filtered_mv <= MV_W'(MV_MAX), "filt out of range")

endmodule

// ===== sv/bvm_front.sv =====
// ----------------------------------------------------------------------------
// bvm_front
// takes samples, drops the first of each group, sums the rest and queues
// the group sum on the last sample
// ----------------------------------------------------------------------------
module bvm_front import bvm_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
  parameter int SUM_W        = $clog2(SAMPLE_COUNT * ADC_FULL + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [ADC_W-1:0]   adc_sample,
  input  queue_status_t      q_status,
  output logic               q_push,
  output logic [SUM_W-1:0]   q_data
);

  localparam int POS_W = $clog2(SAMPLE_COUNT + 1);

  logic [POS_W-1:0] group_position;
  logic [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0] sum_next;
  logic             last;
  logic             accept;

  assign last         = (group_position == POS_W'(SAMPLE_COUNT));
  assign sample_stall = q_status.full && last;
  assign accept       = sample_valid && !sample_stall;
  assign sum_next     = sample_sum + SUM_W'(adc_sample);

  assign q_push = accept && last;
  assign q_data = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= '0;
      sample_sum     <= '0;
    end else if (accept) begin
      if (group_position == '0) begin
        group_position <= POS_W'(1);
        sample_sum     <= '0;
      end else if (last) begin
        group_position <= '0;
        sample_sum     <= '0;
      end else begin
        group_position <= group_position + POS_W'(1);
        sample_sum     <= sum_next;
      end
    end
  end

endmodule

// ===== sv/bvm_queue.sv =====
// ----------------------------------------------------------------------------
// bvm_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module bvm_queue import bvm_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output queue_status_t    status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/bvm_back.sv =====
// ----------------------------------------------------------------------------
// bvm_back
// converts queued group sums to millivolts and updates the smoothed value
// ----------------------------------------------------------------------------
module bvm_back import bvm_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
  parameter int SUM_W        = $clog2(SAMPLE_COUNT * ADC_FULL + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  queue_status_t    q_status,
  input  logic [SUM_W-1:0] q_data,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [ADC_W-1:0] average_raw,
  output logic [MV_W-1:0]  battery_mv,
  output logic [MV_W-1:0]  filtered_mv
);

  // average by reciprocal multiply
  localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLE_COUNT);
  localparam int AVG_PW    = SUM_W + AVG_SHIFT + 1;
  localparam logic [63:0] AVG_RECIP =
    ((64'd1 << AVG_SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);

  // pin millivolts
  localparam int PROD_W    = 24;
  localparam int PIN_SHIFT = PROD_W + ADC_W;
  localparam int PIN_PW    = PROD_W + PROD_W + 1;
  localparam logic [63:0] PIN_RECIP =
    ((64'd1 << PIN_SHIFT) + 64'(ADC_FULL) - 64'd1) / 64'(ADC_FULL);

  // battery millivolts
  localparam int NUM_W    = 17;
  localparam int MV_SHIFT = NUM_W + 2;
  localparam int MV_PW    = NUM_W + MV_SHIFT + 1;
  localparam logic [63:0] MV_RECIP =
    ((64'd1 << MV_SHIFT) + 64'(DIV_DEN) - 64'd1) / 64'(DIV_DEN);

  localparam int SMOOTH_W = MV_W + 2;

  logic advance;

  logic              s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic [ADC_W-1:0]  s1_avg, s2_avg, s3_avg, s4_avg, s5_avg;
  logic [PROD_W-1:0] s2_prod;
  logic [ADC_W-1:0]  s3_pin;
  logic [NUM_W-1:0]  s4_num;
  logic [MV_W-1:0]   s5_meas;
  logic              primed;

  logic [AVG_PW-1:0]   avg_full;
  logic [PIN_PW-1:0]   pin_full;
  logic [MV_PW-1:0]    mv_full;
  logic [SMOOTH_W-1:0] smooth_sum;

  assign advance = !result_valid || !result_stall;
  assign q_pop   = advance && !q_status.empty;

  assign avg_full   = AVG_PW'(q_data) * AVG_PW'(AVG_RECIP);
  assign pin_full   = PIN_PW'(s2_prod) * PIN_PW'(PIN_RECIP);
  assign mv_full    = MV_PW'(s4_num) * MV_PW'(MV_RECIP);
  assign smooth_sum = SMOOTH_W'(filtered_mv) * SMOOTH_W'(3) + SMOOTH_W'(s5_meas)
                      + SMOOTH_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      result_valid <= 1'b0;
      primed       <= 1'b0;
    end else if (advance) begin
      s1_valid     <= q_pop;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      s5_valid     <= s4_valid;
      result_valid <= s5_valid;
      if (s5_valid) begin
        primed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_avg  <= avg_full[AVG_SHIFT +: ADC_W];
      s2_avg  <= s1_avg;
      s2_prod <= PROD_W'(s1_avg) * PROD_W'(VREF_MV) + PROD_W'(ADC_FULL / 2);
      s3_avg  <= s2_avg;
      s3_pin  <= pin_full[PIN_SHIFT +: ADC_W];
      s4_avg  <= s3_avg;
      s4_num  <= NUM_W'(s3_pin) * NUM_W'(DIV_NUM) + NUM_W'(DIV_DEN / 2);
      s5_avg  <= s4_avg;
      s5_meas <= mv_full[MV_SHIFT +: MV_W];
      if (s5_valid) begin
        average_raw <= s5_avg;
        battery_mv  <= s5_meas;
        filtered_mv <= primed ? smooth_sum[2 +: MV_W] : s5_meas;
      end
    end
  end

endmodule
